@@ design/fpw_pkg.sv @@
// Shared types and constants for the frame pacing watchdog.
// Event and outcome codes, register indexes, reset values, config and result structs.
// No dependencies.
package fpw_pkg;

  // Event codes carried on the input tuser
  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_STOP    = 3'd1;
  localparam logic [2:0] ACT_PIXEL   = 3'd2;
  localparam logic [2:0] ACT_CURSOR  = 3'd3;
  localparam logic [2:0] ACT_WAIT    = 3'd4;
  localparam logic [2:0] ACT_LOST    = 3'd5;
  localparam logic [2:0] ACT_FATAL   = 3'd6;
  localparam logic [2:0] ACT_REBUILD = 3'd7;

  // Outcome codes carried on the output tuser
  localparam logic [3:0] OUT_IGNORED   = 4'd0;
  localparam logic [3:0] OUT_DELIVERED = 4'd1;
  localparam logic [3:0] OUT_THROTTLED = 4'd2;
  localparam logic [3:0] OUT_CURSOR    = 4'd3;
  localparam logic [3:0] OUT_WAITING   = 4'd4;
  localparam logic [3:0] OUT_DROPPED   = 4'd5;
  localparam logic [3:0] OUT_REBUILT   = 4'd6;
  localparam logic [3:0] OUT_RETRY     = 4'd7;
  localparam logic [3:0] OUT_GAVE_UP   = 4'd8;
  localparam logic [3:0] OUT_FATAL     = 4'd9;
  localparam logic [3:0] OUT_STARTED   = 4'd10;
  localparam logic [3:0] OUT_STOPPED   = 4'd11;

  // Configuration register indexes
  localparam logic [2:0] REG_TARGET    = 3'd0;
  localparam logic [2:0] REG_STALL     = 3'd1;
  localparam logic [2:0] REG_MAX_RETRY = 3'd2;
  localparam logic [2:0] REG_INIT_TOL  = 3'd3;
  localparam logic [2:0] REG_CAL_LIMIT = 3'd4;

  localparam int CFG_DATA_W  = 26;
  localparam int CFG_INDEX_W = 3;

  // Register values after reset
  localparam logic [19:0] RST_TARGET    = 20'd16666;
  localparam logic [25:0] RST_STALL     = 26'd3000000;
  localparam logic [7:0]  RST_MAX_RETRY = 8'd40;
  localparam logic [19:0] RST_INIT_TOL  = 20'd1000;
  localparam logic [19:0] RST_CAL_LIMIT = 20'd100000;

  // Rebuild failure counter saturates here
  localparam logic [8:0] FAIL_MAX = 9'd511;

  typedef struct packed {
    logic [19:0] frame_interval;
    logic [25:0] stall_timeout;
    logic [7:0]  max_rebuild;
    logic [19:0] initial_tolerance;
    logic [19:0] calibration_limit;
  } cfg_t;

  // Result fields that do not depend on the timestamp width
  typedef struct packed {
    logic [3:0]  outcome;
    logic        delivered;
    logic        is_running;
    logic        needs_rebuild;
    logic [19:0] deadline;
    logic        is_calibrated;
  } res_flags_t;

  // a - b, held at zero when b is not smaller
  function automatic logic [19:0] clamp_sub(input logic [19:0] a, input logic [19:0] b);
    return (a > b) ? (a - b) : 20'd0;
  endfunction

endpackage

@@ design/fpw_cfg.sv @@
// Configuration register file of the frame pacing watchdog.
// Depends on fpw_pkg for register indexes, reset values and cfg_t.
module fpw_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fpw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpw_pkg::CFG_DATA_W-1:0]    cfg_data,
  output fpw_pkg::cfg_t                     cfg
);
  import fpw_pkg::*;

  // Write one register per request; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_interval    <= RST_TARGET;
      cfg.stall_timeout     <= RST_STALL;
      cfg.max_rebuild       <= RST_MAX_RETRY;
      cfg.initial_tolerance <= RST_INIT_TOL;
      cfg.calibration_limit <= RST_CAL_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET:    cfg.frame_interval    <= cfg_data[19:0];
        REG_STALL:     cfg.stall_timeout     <= cfg_data[25:0];
        REG_MAX_RETRY: cfg.max_rebuild       <= cfg_data[7:0];
        REG_INIT_TOL:  cfg.initial_tolerance <= cfg_data[19:0];
        REG_CAL_LIMIT: cfg.calibration_limit <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/fpw_core.sv @@
// Input register, watchdog state and per-event decision logic.
// Depends on fpw_pkg for codes, cfg_t, res_flags_t and clamp_sub.
module fpw_core #(
  parameter int TIME_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fpw_pkg::cfg_t          cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_action,
  input  logic [TIME_BITS-1:0]   in_ts,
  input  logic                   in_api_ok,
  input  logic [13:0]            in_width,
  input  logic [13:0]            in_height,
  output logic                   res_valid,
  input  logic                   res_ready,
  output fpw_pkg::res_flags_t    res_flags,
  output logic [TIME_BITS-1:0]   res_dtime
);
  import fpw_pkg::*;

  function automatic logic [TIME_BITS-1:0] elapsed(input logic [TIME_BITS-1:0] now,
                                                   input logic [TIME_BITS-1:0] since);
    return (now >= since) ? (now - since) : '0;
  endfunction

  // Held request
  logic                 hold_valid;
  logic [2:0]           act;
  logic [TIME_BITS-1:0] ts;
  logic                 api_ok;
  logic [13:0]          nw;
  logic [13:0]          nh;

  // Watchdog state
  logic                 running, running_next;
  logic                 invalid, invalid_next;
  logic [8:0]           fail_cnt, fail_cnt_next;
  logic [TIME_BITS-1:0] last_frame, last_frame_next;
  logic [TIME_BITS-1:0] last_dlv, last_dlv_next;
  logic                 dlv_once, dlv_once_next;
  logic [TIME_BITS-1:0] first_frame, first_frame_next;
  logic                 first_seen, first_seen_next;
  logic                 calibrated, calibrated_next;
  logic [19:0]          deadline, deadline_next;
  logic [13:0]          st_width, st_width_next;
  logic [13:0]          st_height, st_height_next;

  logic [3:0]           outcome;
  logic                 delivered;
  logic [TIME_BITS-1:0] dtime;

  logic                 advance;
  logic [TIME_BITS-1:0] vsync;
  logic                 cal_hit;
  logic [19:0]          dl_eff;
  logic                 throttle;
  logic                 size_changed;
  logic [8:0]           fail_inc;

  assign advance   = hold_valid && res_ready;
  assign in_ready  = !hold_valid || res_ready;
  assign res_valid = hold_valid;

  // Capture a request when empty or whenever the held one moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      act    <= in_action;
      ts     <= in_ts;
      api_ok <= in_api_ok;
      nw     <= in_width;
      nh     <= in_height;
    end
  end

  // Vsync measurement and the deadline it yields for this frame
  assign vsync   = elapsed(ts, first_frame);
  assign cal_hit = !calibrated && first_seen && (vsync != '0) &&
                   (vsync < TIME_BITS'(cfg.calibration_limit));
  assign dl_eff  = cal_hit ? clamp_sub(cfg.frame_interval, {1'b0, vsync[19:1]}) : deadline;
  assign throttle = dlv_once && (elapsed(ts, last_dlv) < TIME_BITS'(dl_eff));

  assign size_changed = (st_width != 14'd0) && (st_height != 14'd0) &&
                        ((nw != st_width) || (nh != st_height));
  assign fail_inc     = (fail_cnt < FAIL_MAX) ? (fail_cnt + 9'd1) : fail_cnt;

  // Decide the outcome and the next state
  always_comb begin
    running_next     = running;
    invalid_next     = invalid;
    fail_cnt_next    = fail_cnt;
    last_frame_next  = last_frame;
    last_dlv_next    = last_dlv;
    dlv_once_next    = dlv_once;
    first_frame_next = first_frame;
    first_seen_next  = first_seen;
    calibrated_next  = calibrated;
    deadline_next    = deadline;
    st_width_next    = st_width;
    st_height_next   = st_height;
    outcome          = OUT_IGNORED;
    delivered        = 1'b0;
    dtime            = '0;
    case (act)
      ACT_START: begin
        if (!running) begin
          running_next    = 1'b1;
          last_frame_next = ts;
          fail_cnt_next   = 9'd0;
          dlv_once_next   = 1'b0;
          first_seen_next = 1'b0;
          calibrated_next = 1'b0;
          deadline_next   = clamp_sub(cfg.frame_interval, cfg.initial_tolerance);
          outcome         = OUT_STARTED;
        end
      end
      ACT_STOP: begin
        running_next = 1'b0;
        outcome      = OUT_STOPPED;
      end
      ACT_REBUILD: begin
        if (running && invalid) begin
          if (api_ok && !size_changed) begin
            st_width_next   = nw;
            st_height_next  = nh;
            invalid_next    = 1'b0;
            fail_cnt_next   = 9'd0;
            last_frame_next = ts;
            outcome         = OUT_REBUILT;
          end else begin
            fail_cnt_next = fail_inc;
            if (fail_inc > {1'b0, cfg.max_rebuild}) begin
              running_next = 1'b0;
              outcome      = OUT_GAVE_UP;
            end else begin
              outcome = OUT_RETRY;
            end
          end
        end
      end
      ACT_PIXEL: begin
        if (running && !invalid) begin
          last_frame_next = ts;
          if (!calibrated && !first_seen) begin
            first_frame_next = ts;
            first_seen_next  = 1'b1;
          end
          if (cal_hit) begin
            deadline_next   = dl_eff;
            calibrated_next = 1'b1;
          end
          if (throttle) begin
            outcome = OUT_THROTTLED;
          end else begin
            last_dlv_next = ts;
            dlv_once_next = 1'b1;
            delivered     = 1'b1;
            dtime         = ts;
            outcome       = OUT_DELIVERED;
          end
        end
      end
      ACT_CURSOR: begin
        if (running && !invalid) begin
          last_frame_next = ts;
          outcome         = OUT_CURSOR;
        end
      end
      ACT_WAIT: begin
        if (running && !invalid) begin
          if (elapsed(ts, last_frame) >= TIME_BITS'(cfg.stall_timeout)) begin
            invalid_next    = 1'b1;
            last_frame_next = ts;
            outcome         = OUT_DROPPED;
          end else begin
            outcome = OUT_WAITING;
          end
        end
      end
      ACT_LOST: begin
        if (running && !invalid) begin
          invalid_next    = 1'b1;
          last_frame_next = ts;
          outcome         = OUT_DROPPED;
        end
      end
      ACT_FATAL: begin
        if (running && !invalid) begin
          running_next = 1'b0;
          outcome      = OUT_FATAL;
        end
      end
      default: ;
    endcase
  end

  // Commit state as the result is handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      invalid     <= 1'b0;
      fail_cnt    <= 9'd0;
      last_frame  <= '0;
      last_dlv    <= '0;
      dlv_once    <= 1'b0;
      first_frame <= '0;
      first_seen  <= 1'b0;
      calibrated  <= 1'b0;
      deadline    <= 20'd0;
      st_width    <= 14'd0;
      st_height   <= 14'd0;
    end else if (advance) begin
      running     <= running_next;
      invalid     <= invalid_next;
      fail_cnt    <= fail_cnt_next;
      last_frame  <= last_frame_next;
      last_dlv    <= last_dlv_next;
      dlv_once    <= dlv_once_next;
      first_frame <= first_frame_next;
      first_seen  <= first_seen_next;
      calibrated  <= calibrated_next;
      deadline    <= deadline_next;
      st_width    <= st_width_next;
      st_height   <= st_height_next;
    end
  end

  assign res_flags.outcome       = outcome;
  assign res_flags.delivered     = delivered;
  assign res_flags.is_running    = running_next;
  assign res_flags.needs_rebuild = invalid_next;
  assign res_flags.deadline      = deadline_next;
  assign res_flags.is_calibrated = calibrated_next;
  assign res_dtime               = dtime;

endmodule

@@ design/fpw_outreg.sv @@
// Result register and master-side packing of the frame pacing watchdog.
// Depends on fpw_pkg for res_flags_t.
module fpw_outreg #(
  parameter int TIME_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                res_valid,
  output logic                                res_ready,
  input  fpw_pkg::res_flags_t                 res_flags,
  input  logic [TIME_BITS-1:0]                res_dtime,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [3:0]                          m_tuser,
  output logic [((TIME_BITS+24+7)/8)*8-1:0]   m_tdata
);
  import fpw_pkg::*;

  localparam int OUT_W = ((TIME_BITS + 24 + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - (TIME_BITS + 24);

  res_flags_t           flags;
  logic [TIME_BITS-1:0] dtime;

  assign res_ready = !m_tvalid || m_tready;

  // Load a new result when empty or when the current one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_ready && res_valid) begin
      flags <= res_flags;
      dtime <= res_dtime;
    end
  end

  assign m_tuser = flags.outcome;

  // Pack fields from the lowest bit up, pad to whole bytes
  if (PAD_W > 0) begin : g_pad
    assign m_tdata = {{PAD_W{1'b0}}, flags.is_calibrated, flags.deadline,
                      flags.needs_rebuild, flags.is_running, dtime, flags.delivered};
  end else begin : g_nopad
    assign m_tdata = {flags.is_calibrated, flags.deadline,
                      flags.needs_rebuild, flags.is_running, dtime, flags.delivered};
  end

endmodule

@@ design/frame_pacing_watchdog.sv @@
// Top level of the frame pacing watchdog: streaming ports, config port, wiring.
// Depends on fpw_pkg, fpw_cfg, fpw_core and fpw_outreg.
//
// Paces and supervises a capture source. Every event request on the slave
// stream (tuser = event code) yields exactly one result on the master stream
// (tuser = outcome code). One request is accepted per clock cycle while the
// master side does not stall; its result passes through the input register,
// then the result register, and the whole state update for an event is
// committed as the result is loaded into the result register. Stalls on the
// master side hold the result register and then the input register.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// and should only be changed while no request is in flight.
module frame_pacing_watchdog #(
  parameter int TIME_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [fpw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fpw_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Event stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tuser: action[2:0]
  input  logic [2:0]                          s_tuser,
  // tdata: timestamp_us, rebuild_api_ok, new_width[13:0], new_height[13:0], zero pad
  input  logic [((TIME_BITS+29+7)/8)*8-1:0]   s_tdata,
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tuser: outcome[3:0]
  output logic [3:0]                          m_tuser,
  // tdata: frame_delivered, delivery_time_us, is_running, needs_rebuild,
  //        deadline_us[19:0], is_calibrated, zero pad
  output logic [((TIME_BITS+24+7)/8)*8-1:0]   m_tdata
);
  import fpw_pkg::*;

  cfg_t                 cfg;
  logic                 res_valid;
  logic                 res_ready;
  res_flags_t           res_flags;
  logic [TIME_BITS-1:0] res_dtime;

  fpw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the event fields from the slave tdata
  fpw_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_ts     (s_tdata[TIME_BITS-1:0]),
    .in_api_ok (s_tdata[TIME_BITS]),
    .in_width  (s_tdata[TIME_BITS+14:TIME_BITS+1]),
    .in_height (s_tdata[TIME_BITS+28:TIME_BITS+15]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_flags (res_flags),
    .res_dtime (res_dtime)
  );

  fpw_outreg #(.TIME_BITS(TIME_BITS)) u_outreg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_flags (res_flags),
    .res_dtime (res_dtime),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

endmodule
